### rtl/csa_pkg.sv
// Shared types and constants for the contiguous slot allocator.
// No dependencies; compiled first.
`default_nettype none

package csa_pkg;

	// Field widths of the request and response beats
	localparam int ACT_W  = 1;
	localparam int POOL_W = 2;
	localparam int LEN_W  = 7;
	localparam int POS_W  = 6;
	localparam int NPOOLS = 4;

	localparam int ROAD_SLOTS_DEF = 64;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 1'b0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 1'b1;

	localparam logic [POOL_W-1:0] POOL_FIRST = 2'd0;
	localparam logic [POOL_W-1:0] POOL_NEXT  = 2'd1;
	localparam logic [POOL_W-1:0] POOL_BEST  = 2'd2;
	localparam logic [POOL_W-1:0] POOL_WORST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_BACKUP,
		ST_SCAN_FIT,
		ST_SCAN_NEXT,
		ST_ALIGN0,
		ST_MARK,
		ST_DONE
	} csa_state_t;

	// Commands to the slot ring
	typedef struct packed {
		logic load;
		logic rot_right;
		logic rot_left;
		logic mark_en;
		logic mark_val;
	} ring_ctrl_t;

endpackage

`default_nettype wire

### rtl/csa_if.sv
// Request and response channel interfaces of the slot allocator.
// Depends on csa_pkg for field widths.
`default_nettype none

interface csa_req_if;
	import csa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [POOL_W-1:0] pool;
	logic [LEN_W-1:0]  run_length;
	logic [POS_W-1:0]  release_start;

	modport source (output valid, action, pool, run_length, release_start, input ready);
	modport sink   (input valid, action, pool, run_length, release_start, output ready);
endinterface

interface csa_rsp_if;
	import csa_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

### rtl/contiguous_slot_allocator.sv
// Top level of the contiguous slot allocator: sequencer, pool bitmaps, rover.
// Depends on csa_pkg, csa_if (csa_req_if, csa_rsp_if) and csa_ring.
//
// Usage
//   req: one beat per allocate or release (action, pool, run_length,
//        release_start). ready is high only while no beat is in work.
//   rsp: exactly one beat per request (found, position), in order.
//   Pools 0..3 use first, next, best and worst fit. Each pool bitmap is
//   ROAD_SLOTS bits; a found run is marked used, a release clears its run.
// Sequence per request (one slot visited per cycle through the ring)
//   release            : one marking lap from accept to result
//   first / best / worst: a full scan lap, then a marking lap
//   next fit           : rover align, back-up, a scan bounded by the step count,
//                        return to slot 0 and a marking lap
//   bad length         : straight to the result, with no scan
//   The rotating ring in csa_ring paces each lap: one slot per cycle.
// Reset: bitmaps all free and rover at slot 0 at once; no clearing pass.
// Stall: the result sits in an output register; a new request is taken
//   while it waits, but the next result holds until rsp is drained.
`default_nettype none

module contiguous_slot_allocator #(
	parameter int ROAD_SLOTS = csa_pkg::ROAD_SLOTS_DEF
) (
	input wire        clk,
	input wire        arst_n,
	csa_req_if.sink   req,
	csa_rsp_if.source rsp
);
	import csa_pkg::*;

	localparam int PW = $clog2(ROAD_SLOTS);      // slot index
	localparam int CW = $clog2(ROAD_SLOTS + 2);  // scan step count, up to R+1
	localparam int RW = $clog2(ROAD_SLOTS + 1);  // free run length, up to R

	csa_state_t state_q, state_d;

	// pool bitmaps, bit k set = slot k used
	logic [NPOOLS-1:0][ROAD_SLOTS-1:0] occ_q;
	logic                              occ_we;
	logic [POS_W-1:0]                  rover_q;
	logic                              rover_we;

	// latched request
	logic [ACT_W-1:0]  act_q, act_d;
	logic [POOL_W-1:0] pool_q, pool_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [POS_W-1:0]  start_q, start_d;   // run start for marking and result

	// scan state
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [RW-1:0]     run_q, run_d;
	logic [POS_W-1:0]  st_q, st_d;         // start of current free run
	logic [RW-1:0]     best_len_q, best_len_d;
	logic              has_q, has_d;
	logic              at_end_q, at_end_d; // next fit ran off the last slot
	logic              res_found_q, res_found_d;

	// output register
	logic              out_valid_q;
	logic              out_found_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_load;

	// ring
	ring_ctrl_t        rctl;
	logic              slot_bit;
	logic [PW-1:0]     pos;
	logic [ROAD_SLOTS-1:0] ring_nxt;

	logic              slot_free;
	logic              better;
	logic              in_run;
	logic [LEN_W-1:0]  pos_x;
	logic [LEN_W-1:0]  run_x;
	logic [LEN_W-1:0]  run_inc;

	csa_ring #(
		.ROAD_SLOTS (ROAD_SLOTS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rctl),
		.load_data (occ_q[req.pool]),
		.slot_bit  (slot_bit),
		.pos       (pos),
		.ring_nxt  (ring_nxt)
	);

	assign slot_free = !slot_bit;
	assign pos_x     = LEN_W'(pos);
	assign run_x     = LEN_W'(run_q);
	assign run_inc   = run_x + LEN_W'(1);
	// marking window: start <= slot < start + len
	assign in_run    = (pos_x >= LEN_W'(start_q)) && ((pos_x - LEN_W'(start_q)) < len_q);
	// best fit keeps the smallest run, worst fit the largest; ties keep the first
	assign better    = !has_q || ((pool_q == POOL_WORST) ? (run_q > best_len_q)
	                                                    : (run_q < best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		pool_d      = pool_q;
		len_d       = len_q;
		start_d     = start_q;
		cnt_d       = cnt_q;
		run_d       = run_q;
		st_d        = st_q;
		best_len_d  = best_len_q;
		has_d       = has_q;
		at_end_d    = at_end_q;
		res_found_d = res_found_q;
		rctl        = '0;
		occ_we      = 1'b0;
		rover_we    = 1'b0;
		out_load    = 1'b0;
		req.ready   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					act_d      = req.action;
					pool_d     = req.pool;
					len_d      = req.run_length;
					start_d    = req.release_start;
					cnt_d      = '0;
					run_d      = '0;
					best_len_d = '0;
					has_d      = 1'b0;
					at_end_d   = 1'b0;
					rctl.load  = 1'b1;
					if (req.action == ACT_RELEASE) begin
						state_d = ST_MARK;
					end else if (req.run_length == '0 ||
					             req.run_length > LEN_W'(ROAD_SLOTS)) begin
						res_found_d = 1'b0;
						start_d     = '0;
						state_d     = ST_DONE;
					end else if (req.pool == POOL_NEXT) begin
						state_d = ST_ALIGN;
					end else begin
						state_d = ST_SCAN_FIT;
					end
				end
			end

			// bring the rover slot under the head
			ST_ALIGN: begin
				if (POS_W'(pos) == rover_q) begin
					state_d = ST_BACKUP;
				end else begin
					rctl.rot_right = 1'b1;
				end
			end

			// step down over free slots, stopping at slot 0 or a used slot
			ST_BACKUP: begin
				if (pos != '0 && slot_free) begin
					rctl.rot_left = 1'b1;
				end else begin
					cnt_d    = '0;
					run_d    = '0;
					at_end_d = 1'b0;
					state_d  = ST_SCAN_NEXT;
				end
			end

			// cyclic scan bounded by the step count; runs cut at the last slot
			ST_SCAN_NEXT: begin
				if (!at_end_q && slot_free && cnt_q <= CW'(ROAD_SLOTS)) begin
					rctl.rot_right = 1'b1;
					at_end_d       = (pos == PW'(ROAD_SLOTS - 1));
					cnt_d          = cnt_q + CW'(1);
					run_d          = run_q + RW'(1);
					if (run_inc == len_q) begin
						start_d     = POS_W'(pos_x + LEN_W'(1) - len_q);
						res_found_d = 1'b1;
						state_d     = ST_ALIGN0;
					end
				end else if (cnt_q <= CW'(ROAD_SLOTS)) begin
					if (at_end_q) begin
						at_end_d = 1'b0;
					end else begin
						rctl.rot_right = 1'b1;
					end
					cnt_d = cnt_q + CW'(1);
					run_d = '0;
				end else begin
					res_found_d = 1'b0;
					start_d     = '0;
					state_d     = ST_DONE;
				end
			end

			// one lap over all slots plus a closing step that ends the last run
			ST_SCAN_FIT: begin
				if (slot_free && cnt_q != CW'(ROAD_SLOTS)) begin
					run_d = run_q + RW'(1);
					if (run_q == '0) begin
						st_d = POS_W'(cnt_q);
					end
					if (pool_q == POOL_FIRST && !has_q && run_inc == len_q) begin
						has_d   = 1'b1;
						start_d = POS_W'(LEN_W'(cnt_q) + LEN_W'(1) - len_q);
					end
				end else begin
					run_d = '0;
					if (pool_q != POOL_FIRST && run_x >= len_q && better) begin
						has_d      = 1'b1;
						start_d    = st_q;
						best_len_d = run_q;
					end
				end
				if (cnt_q == CW'(ROAD_SLOTS)) begin
					if (has_d) begin
						state_d = ST_MARK;
					end else begin
						res_found_d = 1'b0;
						start_d     = '0;
						state_d     = ST_DONE;
					end
				end else begin
					rctl.rot_right = 1'b1;
					cnt_d          = cnt_q + CW'(1);
				end
			end

			ST_ALIGN0: begin
				if (pos == '0) begin
					state_d = ST_MARK;
				end else begin
					rctl.rot_right = 1'b1;
				end
			end

			// set or clear the run over one lap, then write the bitmap back
			ST_MARK: begin
				rctl.rot_right = 1'b1;
				rctl.mark_en   = in_run;
				rctl.mark_val  = (act_q == ACT_ALLOC);
				if (pos == PW'(ROAD_SLOTS - 1)) begin
					occ_we      = 1'b1;
					rover_we    = (act_q == ACT_ALLOC) && (pool_q == POOL_NEXT);
					res_found_d = 1'b1;
					state_d     = ST_DONE;
				end
			end

			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		pool_q      <= pool_d;
		len_q       <= len_d;
		start_q     <= start_d;
		cnt_q       <= cnt_d;
		run_q       <= run_d;
		st_q        <= st_d;
		best_len_q  <= best_len_d;
		has_q       <= has_d;
		at_end_q    <= at_end_d;
		res_found_q <= res_found_d;
		if (out_load) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_found_q ? start_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rover_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (occ_we) begin
				occ_q[pool_q] <= ring_nxt;
			end
			if (rover_we) begin
				rover_q <= start_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = out_found_q;
	assign rsp.position = out_pos_q;

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != ST_IDLE))
		else $error("request beat taken but sequencer stayed idle");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.position == '0))
		else $error("not-found beat with non-zero position");

	a_rover_on_road: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(rover_q) < LEN_W'(ROAD_SLOTS))
		else $error("rover beyond last slot");

	a_occ_only_in_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MARK) |=> $stable(occ_q))
		else $error("bitmap changed outside marking lap");

	a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp.valid && !rsp.ready) |=> (state_q == ST_DONE))
		else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

### rtl/csa_ring.sv
// Circular slot ring: one pool's bitmap, rotated one slot per cycle while commanded.
// Depends on csa_pkg (ring_ctrl_t).
`default_nettype none

module csa_ring #(
	parameter int ROAD_SLOTS = csa_pkg::ROAD_SLOTS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  csa_pkg::ring_ctrl_t             ctrl,
	input  wire  [ROAD_SLOTS-1:0]           load_data,
	output logic                            slot_bit,
	output logic [$clog2(ROAD_SLOTS)-1:0]   pos,
	output logic [ROAD_SLOTS-1:0]           ring_nxt
);
	import csa_pkg::*;

	localparam int PW = $clog2(ROAD_SLOTS);

	logic [ROAD_SLOTS-1:0] ring_q;
	logic [ROAD_SLOTS-1:0] cur;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         pos_d;

	// bit 0 always holds slot pos_q
	always_comb begin
		cur = ring_q;
		if (ctrl.mark_en) begin
			cur[0] = ctrl.mark_val;
		end
		if (ctrl.load) begin
			ring_nxt = load_data;
			pos_d    = '0;
		end else if (ctrl.rot_right) begin
			ring_nxt = {cur[0], cur[ROAD_SLOTS-1:1]};
			pos_d    = (pos_q == PW'(ROAD_SLOTS - 1)) ? '0 : pos_q + PW'(1);
		end else if (ctrl.rot_left) begin
			ring_nxt = {cur[ROAD_SLOTS-2:0], cur[ROAD_SLOTS-1]};
			pos_d    = pos_q - PW'(1);
		end else begin
			ring_nxt = cur;
			pos_d    = pos_q;
		end
	end

	always_ff @(posedge clk) begin
		ring_q <= ring_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_d;
		end
	end

	assign slot_bit = ring_q[0];
	assign pos      = pos_q;

endmodule

`default_nettype wire

### tb/contiguous_slot_allocator_tb.sv
// Self-checking testbench for contiguous_slot_allocator: a directed pass, then random traffic.
// Needs csa_pkg, csa_if and the allocator RTL. A scoreboard class holds its own copy of the
// four pool bitmaps and the rover, and predicts every reply.
`timescale 1ns / 1ps

module contiguous_slot_allocator_tb;
	import csa_pkg::*;

	localparam int ROAD_SLOTS   = ROAD_SLOTS_DEF;
	localparam int RANDOM_BEATS = 1450;
	// Settle time after the last reply, sized from the slowest request (next fit)
	localparam int SETTLE_CYCLES = 5 * ROAD_SLOTS + 16;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [POOL_W-1:0] pool;
		logic [LEN_W-1:0]  run_length;
		logic [POS_W-1:0]  release_start;
	} csa_beat_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} csa_reply_t;

	typedef struct {
		int first;
		int span;
	} held_run_t;

	// Slot map scoreboard: own copy of the bitmaps and rover, plus replies still owed
	class slot_map_book;
		bit [63:0]  pool_map [NPOOLS];
		int         rover_slot;
		csa_reply_t awaited_replies [$];
		int         faults;

		function new();
			foreach (pool_map[p])
				pool_map[p] = '0;
			rover_slot = 0;
			faults = 0;
		endfunction

		// slots at or beyond the road end never count as free
		function bit slot_is_free(int p, int k);
			if (k < 0 || k >= ROAD_SLOTS || k >= 64)
				return 1'b0;
			return !pool_map[p][k];
		endfunction

		function void paint_run(int p, int first, int span, bit used);
			for (int k = first; k < first + span; k++) begin
				if (k >= 0 && k < ROAD_SLOTS && k < 64)
					pool_map[p][k] = used;
			end
		endfunction

		function int first_fit(int len);
			int k;
			for (int st = 0; st + len <= ROAD_SLOTS; st++) begin
				k = 0;
				while (k < len && slot_is_free(int'(POOL_FIRST), st + k))
					k++;
				if (k == len)
					return st;
			end
			return -1;
		endfunction

		// back up over free slots from the rover, then a cyclic scan bounded
		// by ROAD_SLOTS+1 visits; a run is cut at the last slot
		function int next_fit(int len);
			int s, i, steps, run;
			s = rover_slot;
			while (s > 0 && slot_is_free(int'(POOL_NEXT), s))
				s--;
			i = s - 1;
			steps = -1;
			while (steps <= ROAD_SLOTS) begin
				run = 0;
				i = (i + 1 < ROAD_SLOTS) ? i + 1 : 0;
				steps++;
				while (i < ROAD_SLOTS && slot_is_free(int'(POOL_NEXT), i) &&
						steps <= ROAD_SLOTS) begin
					i++;
					steps++;
					run++;
					if (run == len)
						return i - len;
				end
			end
			return -1;
		endfunction

		// smallest (or largest, for worst) free run that fits; first wins a tie
		function int sized_fit(int p, int len, bit worst);
			int i, best, best_len, st, rl;
			i = 0;
			best = -1;
			best_len = 0;
			while (i < ROAD_SLOTS) begin
				if (slot_is_free(p, i)) begin
					st = i;
					while (i < ROAD_SLOTS && slot_is_free(p, i))
						i++;
					rl = i - st;
					if (rl >= len && (best < 0 || (worst ? rl > best_len : rl < best_len))) begin
						best = st;
						best_len = rl;
					end
				end
				i++;
			end
			return best;
		endfunction

		function csa_reply_t note_request(csa_beat_t b);
			csa_reply_t r;
			int len, pos;
			len = int'(b.run_length);
			pos = -1;
			if (b.action == ACT_RELEASE) begin
				paint_run(int'(b.pool), int'(b.release_start), len, 1'b0);
				r.found = 1'b1;
				r.position = b.release_start;
			end else begin
				if (len >= 1 && len <= ROAD_SLOTS) begin
					case (b.pool)
						POOL_FIRST: pos = first_fit(len);
						POOL_NEXT:  pos = next_fit(len);
						POOL_BEST:  pos = sized_fit(int'(POOL_BEST), len, 1'b0);
						default:    pos = sized_fit(int'(POOL_WORST), len, 1'b1);
					endcase
				end
				if (pos >= 0) begin
					paint_run(int'(b.pool), pos, len, 1'b1);
					if (b.pool == POOL_NEXT)
						rover_slot = pos;
					r.found = 1'b1;
					r.position = POS_W'(pos);
				end else begin
					r = '0;
				end
			end
			awaited_replies.push_back(r);
			return r;
		endfunction

		function void check_response(logic found, logic [POS_W-1:0] position);
			csa_reply_t exp;
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none, got found=%0d position=%0d",
					$time, found, position);
				faults++;
				return;
			end
			exp = awaited_replies.pop_front();
			if (found !== exp.found) begin
				$display("%0t: found mismatch, expected %0d, got %0d", $time, exp.found, found);
				faults++;
			end
			if (position !== exp.position) begin
				$display("%0t: position mismatch, expected %0d, got %0d",
					$time, exp.position, position);
				faults++;
			end
		endfunction

		function int waiting();
			return awaited_replies.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet_phase = 1'b0;   // no gaps or stalls while set
	int   stall_left = 0;

	slot_map_book book = new();
	held_run_t held [NPOOLS][$];   // runs believed allocated, per pool

	csa_req_if req ();
	csa_rsp_if rsp ();

	contiguous_slot_allocator #(.ROAD_SLOTS(ROAD_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Reply side: sample at the edge, check each beat, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				book.check_response(rsp.found, rsp.position);
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = int'(pick_gap());
			end
		end
	end

	// One request beat: optional gap, then hold until accepted. valid stays
	// high across back-to-back beats, so it only ever gets one update per edge.
	task automatic send_beat(input csa_beat_t b);
		int unsigned gap;
		csa_reply_t r;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.action        <= b.action;
		req.pool          <= b.pool;
		req.run_length    <= b.run_length;
		req.release_start <= b.release_start;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		r = book.note_request(b);
		if (b.action == ACT_ALLOC && r.found)
			held[b.pool].push_back('{first: int'(r.position), span: int'(b.run_length)});
	endtask

	task automatic send_op(input logic [ACT_W-1:0] act, input logic [POOL_W-1:0] p,
			input int len, input int st);
		csa_beat_t b;
		b.action = act;
		b.pool = p;
		b.run_length = LEN_W'(len);
		b.release_start = POS_W'(st);
		send_beat(b);
	endtask

	// Hold the request side until every owed reply is back
	task automatic drain_replies();
		req.valid <= 1'b0;
		while (book.waiting() != 0)
			@(posedge clk);
	endtask

	// Mostly real alloc/free traffic on tracked runs; a little noise:
	// bad lengths and releases of arbitrary spans
	function automatic csa_beat_t random_beat();
		csa_beat_t b;
		int r, idx, sel;
		b.pool = POOL_W'($urandom_range(0, NPOOLS - 1));
		b.release_start = POS_W'($urandom_range(0, 63));
		r = int'($urandom_range(0, 99));
		if (r < 3) begin
			b.action = ACT_ALLOC;
			b.run_length = $urandom_range(0, 1) ? '0 :
				LEN_W'($urandom_range(ROAD_SLOTS + 1, 127));
		end else if (r < 8) begin
			b.action = ACT_RELEASE;
			b.run_length = LEN_W'($urandom_range(0, 127));
		end else if (held[b.pool].size() > 0 &&
				$urandom_range(0, 99) < 25 + 4 * held[b.pool].size()) begin
			idx = int'($urandom_range(0, held[b.pool].size() - 1));
			b.action = ACT_RELEASE;
			b.release_start = POS_W'(held[b.pool][idx].first);
			b.run_length = LEN_W'(held[b.pool][idx].span);
			held[b.pool].delete(idx);
		end else begin
			b.action = ACT_ALLOC;
			sel = int'($urandom_range(0, 99));
			if (sel < 70)
				b.run_length = LEN_W'($urandom_range(1, 6));
			else if (sel < 92)
				b.run_length = LEN_W'($urandom_range(7, 20));
			else
				b.run_length = LEN_W'($urandom_range(21, ROAD_SLOTS));
		end
		return b;
	endfunction

	initial begin
		req.valid         <= 1'b0;
		req.action        <= ACT_ALLOC;
		req.pool          <= POOL_FIRST;
		req.run_length    <= '0;
		req.release_start <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First fit: whole road, full pool, bad lengths, release past the road end
		send_op(ACT_ALLOC,   POOL_FIRST, ROAD_SLOTS, 63);
		send_op(ACT_ALLOC,   POOL_FIRST, 1, 0);
		send_op(ACT_RELEASE, POOL_FIRST, ROAD_SLOTS, 0);
		send_op(ACT_ALLOC,   POOL_FIRST, 0, 21);
		send_op(ACT_ALLOC,   POOL_FIRST, ROAD_SLOTS + 1, 0);
		send_op(ACT_ALLOC,   POOL_NEXT, 127, 63);
		send_op(ACT_ALLOC,   POOL_FIRST, ROAD_SLOTS, 0);
		send_op(ACT_RELEASE, POOL_FIRST, 127, 63);   // only the last slot clears
		send_op(ACT_RELEASE, POOL_WORST, 0, 42);     // zero-length release
		send_op(ACT_ALLOC,   POOL_FIRST, 1, 0);      // lands on the last slot
		// Next fit: rover moves on, then backs up over freed slots to slot 0
		send_op(ACT_ALLOC,   POOL_NEXT, 10, 0);
		send_op(ACT_ALLOC,   POOL_NEXT, 5, 0);
		send_op(ACT_RELEASE, POOL_NEXT, 12, 0);
		send_op(ACT_ALLOC,   POOL_NEXT, 3, 0);
		send_op(ACT_ALLOC,   POOL_NEXT, 49, 0);
		// Best fit prefers the small hole over the big tail
		send_op(ACT_ALLOC,   POOL_BEST, 8, 0);
		send_op(ACT_ALLOC,   POOL_BEST, 4, 0);
		send_op(ACT_ALLOC,   POOL_BEST, 8, 0);
		send_op(ACT_RELEASE, POOL_BEST, 4, 8);
		send_op(ACT_ALLOC,   POOL_BEST, 3, 0);
		// Worst fit with two equal holes: first one wins
		send_op(ACT_ALLOC,   POOL_WORST, ROAD_SLOTS, 0);
		send_op(ACT_RELEASE, POOL_WORST, 4, 4);
		send_op(ACT_RELEASE, POOL_WORST, 4, 20);
		send_op(ACT_ALLOC,   POOL_WORST, 2, 0);
		send_op(ACT_ALLOC,   POOL_WORST, 4, 0);
		drain_replies();

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			quiet_phase = ((n / 150) % 4) == 3;
			if (n % 300 == 299)
				drain_replies();
			send_beat(random_beat());
		end

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.faults == 0 && book.waiting() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#30_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
